[rtl/apdc_pkg.sv]
package apdc_pkg;

  // field widths
  localparam int unsigned TimeW    = 62;
  localparam int unsigned CntW     = 17;
  localparam int unsigned HeadW    = 64;
  localparam int unsigned BufW     = 63;
  localparam int unsigned RateW    = 18;
  localparam int unsigned LatW     = 21;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 21;

  // serial multiply/divide unit sizing
  localparam int unsigned OpW   = 41;            // multiplicand and quotient width
  localparam int unsigned MulW  = RateW;         // multiplier and divisor width
  localparam int unsigned ProdW = OpW + MulW;    // full product width
  localparam int unsigned StepW = 6;             // width of the multiplicand bit count
  localparam int unsigned CntRegW = 7;           // up to MulW + OpW steps

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSampleRate = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLatency    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPreroll    = 2'd2;

  // configuration reset values
  localparam logic [RateW-1:0] RateReset    = 18'd44100;
  localparam logic [LatW-1:0]  LatReset     = 21'd4179;
  localparam logic [LatW-1:0]  PrerollReset = 21'd0;

  // fifo capacity in samples; timing constants in 180 kHz ticks
  localparam logic [CntW:0]    FifoCapacity = 18'd65536;
  localparam logic [RateW-1:0] TickRate     = 18'd180000;
  localparam logic [LatW-1:0]  DriftTol     = 21'd9000;
  localparam logic [LatW-1:0]  RelClampHi   = 21'd1800000;
  localparam logic [HeadW-1:0] EmptyHead    = 64'd2147483647;
  localparam logic [HeadW-1:0] MagClamp     = 64'h0000_0100_0000_0000;

  // multiplicand lengths per operation
  localparam logic [StepW-1:0] RelSteps = 6'd21;
  localparam logic [StepW-1:0] MagSteps = 6'd41;
  localparam logic [StepW-1:0] AdvSteps = 6'd17;

  typedef struct packed {
    logic             mode;
    logic [TimeW-1:0] time_ticks;
    logic [CntW-1:0]  sample_count;
  } in_t;

  typedef struct packed {
    logic [CntW-1:0] dropped_samples;
    logic [CntW-1:0] lead_silence;
    logic [CntW-1:0] copied_samples;
    logic [CntW-1:0] tail_silence;
    logic            underflow;
    logic            overflow;
  } out_t;

  typedef struct packed {
    logic [RateW-1:0] rate_eff;
    logic [LatW-1:0]  latency;
    logic [LatW-1:0]  preroll;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [OpW-1:0]   a;
    logic [MulW-1:0]  mul;
    logic [MulW-1:0]  div;
    logic [StepW-1:0] steps;
  } mdu_req_t;

  typedef struct packed {
    logic           done;
    logic [OpW-1:0] quot;
  } mdu_rsp_t;

  typedef enum logic [1:0] {
    MDU_IDLE,
    MDU_MUL,
    MDU_DIV
  } mdu_state_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_BUF,
    ST_CMP,
    ST_SCALE,
    ST_LEAD,
    ST_DROP,
    ST_ADV_DROP,
    ST_COPY,
    ST_ADV_COPY,
    ST_DONE
  } state_e;

endpackage

[rtl/apdc_cfg_regs.sv]
module apdc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [apdc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [apdc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output apdc_pkg::cfg_t                 cfg_o
);

  logic [apdc_pkg::RateW-1:0] rate_q, rate_d;
  logic [apdc_pkg::LatW-1:0]  lat_q, lat_d;
  logic [apdc_pkg::LatW-1:0]  preroll_q, preroll_d;

  // register writes, unknown indexes are ignored
  always_comb begin
    rate_d    = rate_q;
    lat_d     = lat_q;
    preroll_d = preroll_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        apdc_pkg::CfgSampleRate: rate_d    = cfg_wdata_i[apdc_pkg::RateW-1:0];
        apdc_pkg::CfgLatency:    lat_d     = cfg_wdata_i[apdc_pkg::LatW-1:0];
        apdc_pkg::CfgPreroll:    preroll_d = cfg_wdata_i[apdc_pkg::LatW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= apdc_pkg::RateReset;
      lat_q     <= apdc_pkg::LatReset;
      preroll_q <= apdc_pkg::PrerollReset;
    end else begin
      rate_q    <= rate_d;
      lat_q     <= lat_d;
      preroll_q <= preroll_d;
    end
  end

  // a zero rate behaves as one
  assign cfg_o.rate_eff = (rate_q == '0) ? apdc_pkg::RateW'(1) : rate_q;
  assign cfg_o.latency  = lat_q;
  assign cfg_o.preroll  = preroll_q;

endmodule

[rtl/apdc_muldiv.sv]
module apdc_muldiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  apdc_pkg::mdu_req_t  req_i,
  output apdc_pkg::mdu_rsp_t  rsp_o
);

  localparam int unsigned ProdW = apdc_pkg::ProdW;
  localparam int unsigned OpW   = apdc_pkg::OpW;
  localparam int unsigned MulW  = apdc_pkg::MulW;

  apdc_pkg::mdu_state_e state_q, state_d;

  logic [ProdW-1:0]               w_q, w_d;
  logic [OpW-1:0]                 a_q, a_d;
  logic [MulW-1:0]                mul_q, mul_d;
  logic [MulW-1:0]                div_q, div_d;
  logic [MulW-1:0]                rem_q, rem_d;
  logic [apdc_pkg::CntRegW-1:0]   cnt_q, cnt_d;
  logic [apdc_pkg::StepW-1:0]     steps_q, steps_d;
  logic                           done_q, done_d;

  logic [MulW:0] mul_sum;
  logic [MulW:0] div_trial;
  logic          div_ge;

  // one multiplicand bit per cycle, lsb first
  assign mul_sum = {1'b0, w_q[ProdW-1 -: MulW]} + (a_q[0] ? {1'b0, mul_q} : '0);

  // one quotient bit per cycle, msb first
  assign div_trial = {rem_q, w_q[ProdW-1]};
  assign div_ge    = div_trial >= {1'b0, div_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      apdc_pkg::MDU_IDLE: if (req_i.start) state_d = apdc_pkg::MDU_MUL;
      apdc_pkg::MDU_MUL:  if (cnt_q == apdc_pkg::CntRegW'(1)) state_d = apdc_pkg::MDU_DIV;
      apdc_pkg::MDU_DIV:  if (cnt_q == apdc_pkg::CntRegW'(1)) state_d = apdc_pkg::MDU_IDLE;
      default:            state_d = apdc_pkg::MDU_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    w_d     = w_q;
    a_d     = a_q;
    mul_d   = mul_q;
    div_d   = div_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    steps_d = steps_q;
    done_d  = 1'b0;
    case (state_q)
      apdc_pkg::MDU_IDLE: begin
        if (req_i.start) begin
          a_d     = req_i.a;
          mul_d   = req_i.mul;
          div_d   = req_i.div;
          steps_d = req_i.steps;
          w_d     = '0;
          rem_d   = '0;
          cnt_d   = apdc_pkg::CntRegW'(req_i.steps);
        end
      end
      apdc_pkg::MDU_MUL: begin
        w_d = {mul_sum, w_q[OpW-1:1]};
        a_d = a_q >> 1;
        if (cnt_q == apdc_pkg::CntRegW'(1)) begin
          // product now sits in the top MulW + steps bits
          cnt_d = apdc_pkg::CntRegW'(MulW) + apdc_pkg::CntRegW'(steps_q);
        end else begin
          cnt_d = cnt_q - apdc_pkg::CntRegW'(1);
        end
      end
      apdc_pkg::MDU_DIV: begin
        rem_d = div_ge ? MulW'(div_trial - {1'b0, div_q}) : div_trial[MulW-1:0];
        w_d   = {w_q[ProdW-2:0], div_ge};
        cnt_d = cnt_q - apdc_pkg::CntRegW'(1);
        if (cnt_q == apdc_pkg::CntRegW'(1)) done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apdc_pkg::MDU_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    a_q     <= a_d;
    mul_q   <= mul_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    steps_q <= steps_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = w_q[OpW-1:0];

endmodule

[rtl/audio_playout_drift_corrector_core.sv]
// Audio playout drift corrector: keeps the fill level (samples) and head timestamp
// (180 kHz ticks) of a sample fifo, returns sample counts for each output request.
// Input channel (in_valid_i / in_stall_o / in_data_i): mode 0 pushes samples, mode 1
// is a fill request carrying the current clock and the requested sample count.
// Output channel (out_valid_o / out_stall_i / out_data_o): exactly one result per
// input transfer, in order.
// Items are processed one at a time. A push passes through the push and done states
// before its result goes to the output register. A fill runs its tick/sample
// conversions through one serial multiply and divide unit that handles one bit
// per cycle. Without correction a fill only copies; with early data it adds lead
// silence first; with late data it drops samples and advances the head before the
// copy and its own head advance.
// The next item is taken as soon as the result has moved to the output register,
// even while the receiver still stalls it; a stalled result holds until taken.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the next
// edge; the user must make them only while no item is in flight (not enforced).
// Reset empties the fifo, clears the head time and restores default settings.
module audio_playout_drift_corrector_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  apdc_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output apdc_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [apdc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [apdc_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam int unsigned CntW  = apdc_pkg::CntW;
  localparam int unsigned HeadW = apdc_pkg::HeadW;
  localparam int unsigned BufW  = apdc_pkg::BufW;
  localparam int unsigned OpW   = apdc_pkg::OpW;
  localparam int unsigned LatW  = apdc_pkg::LatW;

  apdc_pkg::cfg_t     cfg;
  apdc_pkg::mdu_req_t mdu_req;
  apdc_pkg::mdu_rsp_t mdu_rsp;

  apdc_pkg::state_e state_q, state_d;

  logic [apdc_pkg::TimeW-1:0] t_q, t_d;
  logic [CntW-1:0]            rem_q, rem_d;
  logic [CntW-1:0]            level_q, level_d;
  logic [HeadW-1:0]           head_q, head_d;
  logic [BufW-1:0]            buf_q, buf_d;
  logic [HeadW:0]             diff_q, diff_d;
  logic [CntW-1:0]            dropped_q, dropped_d;
  logic [CntW-1:0]            lead_q, lead_d;
  logic [CntW-1:0]            copied_q, copied_d;
  logic                       ovf_q, ovf_d;
  apdc_pkg::out_t             out_q, out_d;
  logic                       out_valid_q, out_valid_d;

  logic             in_xfer;
  logic             out_free;
  logic [CntW:0]    push_sum;
  logic [HeadW-1:0] rel;
  logic [LatW-1:0]  rel_clamped;
  logic [HeadW-1:0] mag;
  logic [OpW-1:0]   mag_clamped;
  logic [CntW-1:0]  lead_take;
  logic [CntW-1:0]  drop_take;
  logic [CntW-1:0]  copy_take;
  logic [HeadW:0]   head_sum;
  logic [HeadW-1:0] head_adv;

  apdc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  apdc_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .rsp_o  (mdu_rsp)
  );

  // handshakes
  assign in_stall_o = (state_q != apdc_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // shared arithmetic
  assign push_sum    = {1'b0, level_q} + {1'b0, rem_q};
  assign rel         = diff_q[HeadW-1:0];
  assign rel_clamped = (rel > HeadW'(apdc_pkg::RelClampHi)) ? apdc_pkg::RelClampHi
                                                            : rel[LatW-1:0];
  assign mag         = ~diff_q[HeadW-1:0] + HeadW'(1);
  assign mag_clamped = (mag > apdc_pkg::MagClamp) ? apdc_pkg::MagClamp[OpW-1:0]
                                                  : mag[OpW-1:0];
  assign lead_take   = (mdu_rsp.quot < OpW'(rem_q)) ? mdu_rsp.quot[CntW-1:0] : rem_q;
  assign drop_take   = (mdu_rsp.quot < OpW'(level_q)) ? mdu_rsp.quot[CntW-1:0] : level_q;
  assign copy_take   = (rem_q < level_q) ? rem_q : level_q;
  assign head_sum    = {1'b0, head_q} + (HeadW + 1)'(mdu_rsp.quot);
  assign head_adv    = head_sum[HeadW] ? '1 : head_sum[HeadW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      apdc_pkg::ST_IDLE: begin
        if (in_xfer) state_d = in_data_i.mode ? apdc_pkg::ST_BUF : apdc_pkg::ST_PUSH;
      end
      apdc_pkg::ST_PUSH: state_d = apdc_pkg::ST_DONE;
      apdc_pkg::ST_BUF:  state_d = apdc_pkg::ST_CMP;
      apdc_pkg::ST_CMP:  state_d = apdc_pkg::ST_SCALE;
      apdc_pkg::ST_SCALE: begin
        if (!diff_q[HeadW]) begin
          state_d = (rel_clamped > apdc_pkg::DriftTol) ? apdc_pkg::ST_LEAD
                                                       : apdc_pkg::ST_COPY;
        end else begin
          state_d = (mag > HeadW'(apdc_pkg::DriftTol)) ? apdc_pkg::ST_DROP
                                                       : apdc_pkg::ST_COPY;
        end
      end
      apdc_pkg::ST_LEAD:     if (mdu_rsp.done) state_d = apdc_pkg::ST_COPY;
      apdc_pkg::ST_DROP:     if (mdu_rsp.done) state_d = apdc_pkg::ST_ADV_DROP;
      apdc_pkg::ST_ADV_DROP: if (mdu_rsp.done) state_d = apdc_pkg::ST_COPY;
      apdc_pkg::ST_COPY: begin
        state_d = (copy_take != '0) ? apdc_pkg::ST_ADV_COPY : apdc_pkg::ST_DONE;
      end
      apdc_pkg::ST_ADV_COPY: if (mdu_rsp.done) state_d = apdc_pkg::ST_DONE;
      apdc_pkg::ST_DONE:     if (out_free) state_d = apdc_pkg::ST_IDLE;
      default:               state_d = apdc_pkg::ST_IDLE;
    endcase
  end

  // datapath and unit requests
  always_comb begin
    t_d       = t_q;
    rem_d     = rem_q;
    level_d   = level_q;
    head_d    = head_q;
    buf_d     = buf_q;
    diff_d    = diff_q;
    dropped_d = dropped_q;
    lead_d    = lead_q;
    copied_d  = copied_q;
    ovf_d     = ovf_q;
    out_d     = out_q;
    mdu_req   = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      apdc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          t_d       = in_data_i.time_ticks;
          rem_d     = in_data_i.sample_count;
          dropped_d = '0;
          lead_d    = '0;
          copied_d  = '0;
          ovf_d     = 1'b0;
        end
      end
      apdc_pkg::ST_PUSH: begin
        // push: set head time on an empty fifo, saturate the level
        if (level_q == '0) head_d = HeadW'(t_q) + HeadW'(cfg.preroll);
        if (push_sum > apdc_pkg::FifoCapacity) begin
          level_d = apdc_pkg::FifoCapacity[CntW-1:0];
          ovf_d   = 1'b1;
        end else begin
          level_d = push_sum[CntW-1:0];
        end
        rem_d = '0;
      end
      apdc_pkg::ST_BUF: begin
        buf_d = BufW'(t_q) + BufW'(cfg.latency);
        if (level_q == '0) head_d = apdc_pkg::EmptyHead;
      end
      apdc_pkg::ST_CMP: begin
        diff_d = {1'b0, head_q} - (HeadW + 1)'(buf_q);
      end
      apdc_pkg::ST_SCALE: begin
        // convert drift ticks to samples
        if (!diff_q[HeadW]) begin
          if (rel_clamped > apdc_pkg::DriftTol) begin
            mdu_req.start = 1'b1;
            mdu_req.a     = OpW'(rel_clamped);
            mdu_req.mul   = cfg.rate_eff;
            mdu_req.div   = apdc_pkg::TickRate;
            mdu_req.steps = apdc_pkg::RelSteps;
          end
        end else if (mag > HeadW'(apdc_pkg::DriftTol)) begin
          mdu_req.start = 1'b1;
          mdu_req.a     = mag_clamped;
          mdu_req.mul   = cfg.rate_eff;
          mdu_req.div   = apdc_pkg::TickRate;
          mdu_req.steps = apdc_pkg::MagSteps;
        end
      end
      apdc_pkg::ST_LEAD: begin
        if (mdu_rsp.done) begin
          lead_d = lead_take;
          rem_d  = rem_q - lead_take;
        end
      end
      apdc_pkg::ST_DROP: begin
        // drop late samples, then advance the head by their duration
        if (mdu_rsp.done) begin
          dropped_d     = drop_take;
          level_d       = level_q - drop_take;
          mdu_req.start = 1'b1;
          mdu_req.a     = OpW'(drop_take);
          mdu_req.mul   = apdc_pkg::TickRate;
          mdu_req.div   = cfg.rate_eff;
          mdu_req.steps = apdc_pkg::AdvSteps;
        end
      end
      apdc_pkg::ST_ADV_DROP: begin
        if (mdu_rsp.done) head_d = head_adv;
      end
      apdc_pkg::ST_COPY: begin
        // copy what the fifo holds, the rest becomes tail silence
        copied_d = copy_take;
        level_d  = level_q - copy_take;
        rem_d    = rem_q - copy_take;
        if (copy_take != '0) begin
          mdu_req.start = 1'b1;
          mdu_req.a     = OpW'(copy_take);
          mdu_req.mul   = apdc_pkg::TickRate;
          mdu_req.div   = cfg.rate_eff;
          mdu_req.steps = apdc_pkg::AdvSteps;
        end
      end
      apdc_pkg::ST_ADV_COPY: begin
        if (mdu_rsp.done) head_d = head_adv;
      end
      apdc_pkg::ST_DONE: begin
        if (out_free) begin
          out_d.dropped_samples = dropped_q;
          out_d.lead_silence    = lead_q;
          out_d.copied_samples  = copied_q;
          out_d.tail_silence    = rem_q;
          out_d.underflow       = (rem_q != '0);
          out_d.overflow        = ovf_q;
          out_valid_d           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apdc_pkg::ST_IDLE;
      level_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q       <= t_d;
    rem_q     <= rem_d;
    buf_q     <= buf_d;
    diff_q    <= diff_d;
    dropped_q <= dropped_d;
    lead_q    <= lead_d;
    copied_q  <= copied_d;
    ovf_q     <= ovf_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[tb/audio_playout_drift_corrector_core_tb.sv]
module audio_playout_drift_corrector_core_tb;
  import apdc_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam logic ModePush = 1'b0;
  localparam logic ModeFill = 1'b1;
  localparam logic [63:0] TimeMax = 64'({TimeW{1'b1}});

  // block ports
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // shadow settings and fifo bookkeeping
  logic [RateW-1:0] rate_reg  = RateReset;
  logic [LatW-1:0]  lat_reg   = LatReset;
  logic [LatW-1:0]  pre_reg   = PrerollReset;
  int unsigned      fifo_fill = 0;
  logic [63:0]      head_tick = '0;

  // stimulus state
  in_t         item_q[$];
  out_t        expected_counts[$];
  out_t        want;
  logic [63:0] wall_tick, media_tick;
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 57;
  int unsigned stall_hold    = 0;
  int unsigned err_cnt       = 0;
  int unsigned cycle_cnt     = 0;

  audio_playout_drift_corrector_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // tick/sample scaling base, a zero rate counts as one
  function automatic logic [63:0] rate_eff();
    return (rate_reg == '0) ? 64'd1 : 64'(rate_reg);
  endfunction

  // remove n samples from the head and move the head time on, saturating
  function automatic void take_samples(int unsigned n);
    logic [64:0] sum;
    sum = {1'b0, head_tick} + 65'((64'(n) * 64'(TickRate)) / rate_eff());
    fifo_fill -= n;
    head_tick = sum[64] ? '1 : sum[63:0];
  endfunction

  // expected counts for one item, updates fifo level and head time
  function automatic out_t predict_playout(in_t item);
    out_t        res;
    logic [63:0] buf_tick, drift, scaled;
    int unsigned left, take;
    res = '0;
    if (item.mode == ModePush) begin
      // refill of an empty fifo restarts the head time
      if (fifo_fill == 0) head_tick = 64'(item.time_ticks) + 64'(pre_reg);
      if (fifo_fill + item.sample_count > FifoCapacity) begin
        fifo_fill = FifoCapacity;
        res.overflow = 1'b1;
      end else begin
        fifo_fill += item.sample_count;
      end
    end else begin
      buf_tick = 64'(item.time_ticks) + 64'(lat_reg);
      left = item.sample_count;
      if (fifo_fill == 0) head_tick = EmptyHead;
      if (head_tick >= buf_tick) begin
        // early data gets leading silence
        drift = head_tick - buf_tick;
        if (drift > 64'(RelClampHi)) drift = 64'(RelClampHi);
        if (drift > 64'(DriftTol)) begin
          scaled = drift * rate_eff() / 64'(TickRate);
          res.lead_silence = (scaled < 64'(left)) ? CntW'(scaled) : CntW'(left);
          left -= res.lead_silence;
        end
      end else begin
        // late data is dropped from the head
        drift = buf_tick - head_tick;
        if (drift > 64'(DriftTol)) begin
          if (drift > MagClamp) drift = MagClamp;
          scaled = drift * rate_eff() / 64'(TickRate);
          res.dropped_samples = (scaled < 64'(fifo_fill)) ? CntW'(scaled) : CntW'(fifo_fill);
          take_samples(res.dropped_samples);
        end
      end
      // copy what is there, pad the rest
      take = (left < fifo_fill) ? left : fifo_fill;
      if (take != 0) take_samples(take);
      res.copied_samples = CntW'(take);
      res.tail_silence = CntW'(left - take);
      res.underflow = (left != take);
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [CntW-1:0] want_v,
                                      logic [CntW-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
      err_cnt++;
    end
  endfunction

  task automatic queue_item(logic mode, logic [63:0] t, int unsigned n);
    in_t item;
    item.mode = mode;
    item.time_ticks = t[TimeW-1:0];
    item.sample_count = CntW'(n);
    item_q.push_back(item);
  endtask

  // time offset around a stream position, spread within and beyond the tolerance, some on its edge
  function automatic logic [63:0] jitter(logic [63:0] base);
    int unsigned r, mag;
    r = $urandom_range(99);
    if (r < 45) mag = $urandom_range(8999);
    else if (r < 80) mag = $urandom_range(60000, 9001);
    else if (r < 94) mag = $urandom_range(2000000, 60001);
    else mag = $urandom_range(9001, 9000);
    return $urandom_range(1) ? base + mag : base - mag;
  endfunction

  function automatic int unsigned pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return 0;
    if (r < 9) return 32'(FifoCapacity);
    if (r < 16) return $urandom_range(32'(FifoCapacity));
    return $urandom_range(2048, 1);
  endfunction

  function automatic logic [63:0] random_base();
    return (64'({$urandom, $urandom}) >> 3) + 64'd4000000;
  endfunction

  // align media and wall clocks so pushed data lands near the playout point
  task automatic start_stream(logic [63:0] base);
    wall_tick = base;
    media_tick = base + 64'(lat_reg) - 64'(pre_reg);
  endtask

  // well-formed push/fill stream with some arbitrary items mixed in
  task automatic queue_stream(int unsigned n);
    int unsigned cnt;
    logic        mode;
    for (int unsigned i = 0; i < n; i++) begin
      cnt = pick_count();
      mode = $urandom_range(1);
      if ($urandom_range(99) < 5) begin
        queue_item(mode, 64'({$urandom, $urandom}), $urandom_range(32'(FifoCapacity)));
      end else if (mode == ModePush) begin
        queue_item(mode, jitter(media_tick), cnt);
        media_tick += 64'(cnt) * 64'(TickRate) / rate_eff();
      end else begin
        queue_item(mode, jitter(wall_tick), cnt);
        wall_tick += 64'(cnt) * 64'(TickRate) / rate_eff();
      end
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgSampleRate: rate_reg = val[RateW-1:0];
      CfgLatency:    lat_reg = val[LatW-1:0];
      CfgPreroll:    pre_reg = val[LatW-1:0];
      default: ;
    endcase
  endtask

  // block until every queued item is sent and every result is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (item_q.size() != 0 || in_valid_i || expected_counts.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // sender: predict on each transfer, then offer the next item
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) expected_counts.push_back(predict_playout(in_data_i));
    if (!in_valid_i || !in_stall_o) begin
      if (rst_ni && item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data_i <= item_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: check each transfer, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %p", $time, out_data_o);
        err_cnt++;
      end else begin
        want = expected_counts.pop_front();
        check_field("dropped_samples", want.dropped_samples, out_data_o.dropped_samples);
        check_field("lead_silence", want.lead_silence, out_data_o.lead_silence);
        check_field("copied_samples", want.copied_samples, out_data_o.copied_samples);
        check_field("tail_silence", want.tail_silence, out_data_o.tail_silence);
        check_field("underflow", want.underflow, out_data_o.underflow);
        check_field("overflow", want.overflow, out_data_o.overflow);
      end
    end
    if (stall_hold != 0) begin
      stall_hold--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("audio_playout_drift_corrector_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed items at reset settings
    queue_item(ModeFill, 0, 1000);            // empty fifo, head far in the future
    queue_item(ModeFill, 0, 0);               // empty request
    queue_item(ModePush, 0, 0);               // push of nothing
    queue_item(ModePush, 1000, 65536);        // fill to capacity
    queue_item(ModePush, 5, 1);               // overflow by one
    queue_item(ModePush, 5, 65536);           // overflow by a full push
    queue_item(ModeFill, 0, 65536);           // in tolerance, take everything
    queue_item(ModeFill, 0, 100);             // empty again, all early silence
    queue_item(ModePush, 200000, 300);
    queue_item(ModeFill, 195821, 1000);       // underflow with tail padding
    queue_item(ModePush, 500000, 20000);
    queue_item(ModeFill, 504821, 10);         // late exactly on the tolerance
    queue_item(ModeFill, 504862, 10);         // late just past it, drop
    queue_item(ModeFill, 495901, 10);         // early exactly on the tolerance
    queue_item(ModeFill, 495940, 3000);       // early just past it, lead silence
    queue_item(ModeFill, 0, 500);             // very early, silence capped by request
    queue_item(ModePush, TimeMax, 7);
    queue_item(ModeFill, TimeMax, 5);         // very late, drop clamps to whole fifo
    queue_item(ModePush, TimeMax, 100);       // refill with largest media time
    queue_item(ModeFill, 0, 50);              // early beyond the upper clamp
    queue_item(ModeFill, TimeMax, 200);       // small lateness, partial underflow
    wait_drained();
    start_stream(64'($urandom_range(2000000000, 4000000)));
    queue_stream(150);
    wait_drained();

    // fastest rate, no latency, largest preroll
    write_reg(CfgSampleRate, 21'd192000);
    write_reg(CfgLatency, 21'd0);
    write_reg(CfgPreroll, 21'd1800000);
    start_stream(random_base());
    queue_stream(170);
    wait_drained();

    // slowest rate, largest latency, no preroll; pause for a full drain midway
    send_idle_pct = 57;
    recv_idle_pct = 19;
    write_reg(CfgSampleRate, 21'd1);
    write_reg(CfgLatency, 21'd1800000);
    write_reg(CfgPreroll, 21'd0);
    start_stream(64'($urandom_range(2000000000, 4000000)));
    queue_stream(85);
    wait_drained();
    queue_stream(85);
    wait_drained();

    // common rate, random latency and preroll
    write_reg(CfgSampleRate, 21'd48000);
    write_reg(CfgLatency, CfgDataW'($urandom_range(1800000)));
    write_reg(CfgPreroll, CfgDataW'($urandom_range(1800000)));
    start_stream(random_base());
    queue_stream(170);
    wait_drained();

    // no idling, long receiver hold-off at the start to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_hold = 600;
    write_reg(CfgSampleRate, 21'd44100);
    write_reg(CfgLatency, 21'd4179);
    write_reg(CfgPreroll, CfgDataW'($urandom_range(9000)));
    start_stream(64'($urandom_range(2000000000, 4000000)));
    queue_stream(170);
    wait_drained();

    repeat (250) @(posedge clk_i);
    if (err_cnt == 0 && expected_counts.size() == 0) begin
      $display("audio_playout_drift_corrector_core test passed");
    end else begin
      $display("audio_playout_drift_corrector_core test failed");
    end
    $finish;
  end

endmodule
